[hw/rtl/gpslap_pkg.sv]
// ----------------------------------------------------------------------------
// gpslap_pkg
// Shared types and constants of the GPS lap gate timer.
// ----------------------------------------------------------------------------
package gpslap_pkg;

  // Field widths
  localparam int LatW  = 31;
  localparam int LonW  = 32;
  localparam int SpdW  = 16;
  localparam int TimeW = 32;
  localparam int InW   = 112;   // 111 packed bits, padded to whole bytes
  localparam int OutW  = 64;
  localparam int CfgIdxW = 4;
  localparam int CfgW  = 32;

  // Arithmetic widths
  localparam int OpW    = 33;   // coordinate differences
  localparam int ProdW  = 66;   // one signed product
  localparam int CrossW = 67;   // difference of two products
  localparam int MagW   = 67;   // magnitude of a cross product
  localparam int SumW   = 68;   // a + b
  localparam int DenW   = 69;   // 2 * (a + b)
  localparam int AccW   = 83;   // a * gap
  localparam int RemW   = 86;   // dividend and remainder
  localparam int QW     = 17;   // quotient bits
  localparam int CntW   = 5;

  // Sequencer counts
  localparam logic [CntW-1:0] MulLast  = 5'd8;
  localparam logic [CntW-1:0] NmulLast = 5'd15;
  localparam logic [CntW-1:0] DivFirst = 5'd16;

  // Gate limits
  localparam logic signed [31:0] LatLim = 32'sd900000000;
  localparam logic signed [31:0] LonLim = 32'sd1800000000;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_ENABLE = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_LLAT   = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_LLON   = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_RLAT   = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_RLON   = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_MAXGAP = 4'd5;
  localparam logic [CfgIdxW-1:0] REG_MINSPD = 4'd6;
  localparam logic [CfgIdxW-1:0] REG_MINLAP = 4'd7;

  // Crossing direction codes
  localparam logic [1:0] DIR_ANY     = 2'd0;
  localparam logic [1:0] DIR_NEG_POS = 2'd1;
  localparam logic [1:0] DIR_POS_NEG = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic            load;
    logic            commit;
    logic            mul;
    logic            ab_load;
    logic            nmul;
    logic            num_form;
    logic            div_step;
    logic            finish;
    logic [CntW-1:0] cnt;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pre_ok;
    logic have_prev;
    logic gap_ok;
    logic speed_ok;
    logic go;
    logic out_free;
  } status_t;

endpackage

[hw/rtl/gpslap_ctrl.sv]
// ----------------------------------------------------------------------------
// gpslap_ctrl
// Sequencer of the lap gate timer: steps one fix through checks, cross
// products, interpolation multiply, division and the final update.
// ----------------------------------------------------------------------------
module gpslap_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gpslap_pkg::status_t st,
  output gpslap_pkg::cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CHECK  = 4'd1;
  localparam logic [3:0] ST_MUL    = 4'd2;
  localparam logic [3:0] ST_DECIDE = 4'd3;
  localparam logic [3:0] ST_NMUL   = 4'd4;
  localparam logic [3:0] ST_NUMF   = 4'd5;
  localparam logic [3:0] ST_DIV    = 4'd6;
  localparam logic [3:0] ST_FINISH = 4'd7;

  logic [3:0] state, state_next;
  logic [gpslap_pkg::CntW-1:0] cnt, cnt_next;

  assign in_ready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.cnt    = cnt;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!st.pre_ok) begin
          state_next = ST_IDLE;
        end else if (st.have_prev && st.gap_ok && st.speed_ok) begin
          cnt_next   = '0;
          state_next = ST_MUL;
        end else begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        if (cnt == gpslap_pkg::MulLast) begin
          state_next = ST_DECIDE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DECIDE: begin
        if (st.go) begin
          cmd.ab_load = 1'b1;
          cnt_next    = '0;
          state_next  = ST_NMUL;
        end else begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_NMUL: begin
        cmd.nmul = 1'b1;
        if (cnt == gpslap_pkg::NmulLast) begin
          state_next = ST_NUMF;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_NUMF: begin
        cmd.num_form = 1'b1;
        cnt_next     = gpslap_pkg::DivFirst;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_FINISH;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_FINISH: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

[hw/rtl/gpslap_dp.sv]
// ----------------------------------------------------------------------------
// gpslap_dp
// Datapath of the lap gate timer: configuration registers, fix registers,
// shared signed multiplier, serial multiply, restoring divider, lap state
// and the result register.
// ----------------------------------------------------------------------------
module gpslap_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  gpslap_pkg::cmd_t                    cmd,
  output gpslap_pkg::status_t                 st,
  input  logic [gpslap_pkg::InW-1:0]          in_data,
  input  logic                                cfg_we,
  input  logic [gpslap_pkg::CfgIdxW-1:0]      cfg_idx,
  input  logic [gpslap_pkg::CfgW-1:0]         cfg_wdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [gpslap_pkg::OutW-1:0]         out_data
);

  // Configuration
  logic                                   enable;
  logic signed [gpslap_pkg::LatW-1:0]     llat, rlat;
  logic signed [gpslap_pkg::LonW-1:0]     llon, rlon;
  logic [15:0]                            max_gap, min_spd;
  logic [31:0]                            min_lap;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable  <= 1'b0;
      llat    <= '0;
      llon    <= '0;
      rlat    <= '0;
      rlon    <= '0;
      max_gap <= 16'd3000;
      min_spd <= 16'd1000;
      min_lap <= 32'd10000;
    end else if (cfg_we) begin
      case (cfg_idx)
        gpslap_pkg::REG_ENABLE: enable  <= cfg_wdata[0];
        gpslap_pkg::REG_LLAT:   llat    <= cfg_wdata[30:0];
        gpslap_pkg::REG_LLON:   llon    <= cfg_wdata;
        gpslap_pkg::REG_RLAT:   rlat    <= cfg_wdata[30:0];
        gpslap_pkg::REG_RLON:   rlon    <= cfg_wdata;
        gpslap_pkg::REG_MAXGAP: max_gap <= cfg_wdata[15:0];
        gpslap_pkg::REG_MINSPD: min_spd <= cfg_wdata[15:0];
        gpslap_pkg::REG_MINLAP: min_lap <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Current and previous fix
  logic signed [gpslap_pkg::LatW-1:0] cur_lat, prev_lat;
  logic signed [gpslap_pkg::LonW-1:0] cur_lon, prev_lon;
  logic [15:0] cur_spd, prev_spd;
  logic [31:0] cur_ts, prev_ts;
  logic        have_prev;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_lat <= in_data[30:0];
      cur_lon <= in_data[62:31];
      cur_spd <= in_data[78:63];
      cur_ts  <= in_data[110:79];
    end
    if (cmd.commit) begin
      prev_lat <= cur_lat;
      prev_lon <= cur_lon;
      prev_spd <= cur_spd;
      prev_ts  <= cur_ts;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (cmd.commit) begin
      have_prev <= 1'b1;
    end
  end

  // Gate validity and fix checks
  logic signed [31:0] llat_x, rlat_x;
  logic gate_ok;
  logic [31:0] gap;
  assign llat_x = {llat[30], llat};
  assign rlat_x = {rlat[30], rlat};
  assign gate_ok = (llat_x >= -gpslap_pkg::LatLim) && (llat_x <= gpslap_pkg::LatLim) &&
                   (rlat_x >= -gpslap_pkg::LatLim) && (rlat_x <= gpslap_pkg::LatLim) &&
                   (llon >= -gpslap_pkg::LonLim) && (llon <= gpslap_pkg::LonLim) &&
                   (rlon >= -gpslap_pkg::LonLim) && (rlon <= gpslap_pkg::LonLim) &&
                   ((llat != rlat) || (llon != rlon));
  assign gap = cur_ts - prev_ts;

  // Coordinates sign-extended to 33-bit signed
  logic signed [gpslap_pkg::OpW-1:0] clat, clon, plat, plon, glat, glon, rla, rlo;
  assign clat = {{2{cur_lat[30]}}, cur_lat};
  assign clon = {cur_lon[31], cur_lon};
  assign plat = {{2{prev_lat[30]}}, prev_lat};
  assign plon = {prev_lon[31], prev_lon};
  assign glat = {{2{llat[30]}}, llat};
  assign glon = {llon[31], llon};
  assign rla  = {{2{rlat[30]}}, rlat};
  assign rlo  = {rlon[31], rlon};

  // Operand select for the shared multiplier
  logic signed [gpslap_pkg::OpW-1:0] op_a, op_b;
  always_comb begin
    case (cmd.cnt[2:0])
      3'd0: begin op_a = rlo - glon;  op_b = plat - glat; end
      3'd1: begin op_a = rla - glat;  op_b = plon - glon; end
      3'd2: begin op_a = rlo - glon;  op_b = clat - glat; end
      3'd3: begin op_a = rla - glat;  op_b = clon - glon; end
      3'd4: begin op_a = clon - plon; op_b = glat - plat; end
      3'd5: begin op_a = clat - plat; op_b = glon - plon; end
      3'd6: begin op_a = clon - plon; op_b = rla - plat;  end
      default: begin op_a = clat - plat; op_b = rlo - plon; end
    endcase
  end

  // Product register and cross product accumulation
  logic signed [gpslap_pkg::ProdW-1:0]  prod;
  logic signed [gpslap_pkg::CrossW-1:0] xp [4];
  logic [2:0] acc_idx;
  assign acc_idx = 3'(cmd.cnt - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= op_a * op_b;
      if (cmd.cnt != '0) begin
        if (acc_idx[0]) begin
          xp[acc_idx[2:1]] <= xp[acc_idx[2:1]] - {prod[65], prod};
        end else begin
          xp[acc_idx[2:1]] <= {prod[65], prod};
        end
      end
    end
  end

  // Direction and segment test
  logic ps_neg, ps_zero, cs_neg, cs_zero, o1_neg, o1_zero, o2_neg, o2_zero;
  logic [1:0] dir, lock;
  assign ps_neg  = xp[0][66];
  assign ps_zero = (xp[0] == '0);
  assign cs_neg  = xp[1][66];
  assign cs_zero = (xp[1] == '0);
  assign o1_neg  = xp[2][66];
  assign o1_zero = (xp[2] == '0);
  assign o2_neg  = xp[3][66];
  assign o2_zero = (xp[3] == '0);

  always_comb begin
    if (ps_neg && !cs_neg && !cs_zero) begin
      dir = gpslap_pkg::DIR_NEG_POS;
    end else if (!ps_neg && !ps_zero && cs_neg) begin
      dir = gpslap_pkg::DIR_POS_NEG;
    end else begin
      dir = gpslap_pkg::DIR_ANY;
    end
  end

  // Interpolation: a = |ps|, b = |ps| + |cs|
  logic [gpslap_pkg::MagW-1:0] a_mag, ps_abs, cs_abs;
  logic [gpslap_pkg::SumW-1:0] b_sum;
  logic [gpslap_pkg::AccW-1:0] acc;
  logic [gpslap_pkg::RemW-1:0] rem, trial;
  logic [gpslap_pkg::DenW-1:0] den;
  logic [gpslap_pkg::QW-1:0]   quo;
  logic [1:0] dir_q;
  assign ps_abs = ps_neg ? 67'(-xp[0]) : 67'(xp[0]);
  assign cs_abs = cs_neg ? 67'(-xp[1]) : 67'(xp[1]);
  assign den    = {b_sum, 1'b0};
  assign trial  = 86'({17'd0, den} << cmd.cnt);

  always_ff @(posedge clk) begin
    if (cmd.ab_load) begin
      a_mag <= ps_abs;
      b_sum <= {1'b0, ps_abs} + {1'b0, cs_abs};
      acc   <= '0;
      dir_q <= dir;
    end
    // gap times a, one bit of the gap a cycle
    if (cmd.nmul && gap[cmd.cnt[3:0]]) begin
      acc <= acc + (83'(a_mag) << cmd.cnt[3:0]);
    end
    if (cmd.num_form) begin
      rem <= {2'b0, acc, 1'b0} + 86'(b_sum);
      quo <= '0;
    end
    // restoring divide, one quotient bit a cycle
    if (cmd.div_step && (rem >= trial)) begin
      rem <= rem - trial;
      quo[cmd.cnt] <= 1'b1;
    end
  end

  // Crossing time and lap state
  logic [31:0] off, ct, lap, lap_start;
  logic        armed;
  assign off = (32'(quo) > gap) ? gap : 32'(quo);
  assign ct  = prev_ts + off;
  assign lap = ct - lap_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0;
      lock  <= gpslap_pkg::DIR_ANY;
    end else if (cmd.finish && !armed) begin
      armed <= 1'b1;
      lock  <= dir_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && (!armed || lap >= min_lap)) begin
      lap_start <= ct;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish && armed && lap >= min_lap) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && armed && lap >= min_lap) begin
      out_data <= {ct, lap};
    end
  end

  // Status to the controller
  assign st.pre_ok    = enable && gate_ok;
  assign st.have_prev = have_prev;
  assign st.gap_ok    = (gap != '0) && (gap <= {16'd0, max_gap});
  assign st.speed_ok  = ({1'b0, prev_spd} + {1'b0, cur_spd}) >= {min_spd, 1'b0};
  assign st.go        = (dir != gpslap_pkg::DIR_ANY) &&
                        ((lock == gpslap_pkg::DIR_ANY) || (lock == dir)) &&
                        ((o1_neg != o2_neg) || (o1_zero != o2_zero));
  assign st.out_free  = !out_valid || out_ready;

endmodule

[hw/rtl/gps_lap_gate_timer_core.sv]
// Sequence: an accepted fix steps through check, multiply, decide, serial
//   multiply, form, divide steps and finish, which writes any lap result.
// Throughput: one fix at a time; the next fix is accepted only when the
//   sequence is back in idle, after a crossing fix, a direction reject or an
//   early reject; a stalled result holds the sequence in its last step.
// Reset: synchronous, clears configuration to defaults and timer state.
// ----------------------------------------------------------------------------
// gps_lap_gate_timer_core
// GPS lap timer: detects start/finish gate crossings and reports lap times.
// ----------------------------------------------------------------------------
module gps_lap_gate_timer_core (
  input  logic                                clk,
  input  logic                                rst,
  // fields: latitude[30:0], longitude[62:31], speed[78:63], timestamp_ms[110:79]
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [gpslap_pkg::InW-1:0]          s_tdata,
  // fields: lap_time_ms[31:0], crossing_time_ms[63:32]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [gpslap_pkg::OutW-1:0]         m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gpslap_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [gpslap_pkg::CfgW-1:0]         cfg_data
);

  gpslap_pkg::cmd_t    cmd;
  gpslap_pkg::status_t st;

  assign cfg_ready = 1'b1;

  gpslap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  gpslap_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_data   (s_tdata),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

[hw/rtl/gpslap_checker.sv]
// ----------------------------------------------------------------------------
// gpslap_checker
// Port level assertions for the lap gate timer core.
// ----------------------------------------------------------------------------
module gpslap_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [gpslap_pkg::OutW-1:0] m_tdata,
  input logic cfg_ready
);

  // a held result keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one fix in flight: no new beat right after an accepted beat
  a_one_fix: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after accept");

  // results appear only while a fix is being processed
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result without a fix in flight");

  // reset empties the result register; config always taken
  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid && cfg_ready)
    else $error("result valid after reset");

endmodule

bind gps_lap_gate_timer_core gpslap_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_ready (cfg_ready)
);

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the GPS lap gate timer: fixes are streamed in with
// random gaps, a lap predictor computes the expected lap results, and each
// result beat is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic [gpslap_pkg::LatW-1:0]  lat;
    logic [gpslap_pkg::LonW-1:0]  lon;
    logic [gpslap_pkg::SpdW-1:0]  spd;
    logic [gpslap_pkg::TimeW-1:0] ts;
  } fix_t;

  typedef struct {
    logic [31:0] lap;
    logic [31:0] ct;
  } lap_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [gpslap_pkg::InW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [gpslap_pkg::OutW-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [gpslap_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [gpslap_pkg::CfgW-1:0] cfg_data = '0;

  fix_t fix_q[$];
  lap_t lap_q[$];
  fix_t cur_fix;
  int   errors = 0;
  bit   hold_tx = 1'b0;
  bit   no_idle = 1'b0;
  int   tx_gap = 0;
  int   rx_stall = 0;

  // predictor configuration copy
  bit          c_en;
  longint      c_llat, c_llon, c_rlat, c_rlon;
  logic [15:0] c_maxgap, c_minspd;
  logic [31:0] c_minlap;
  // predictor timer state
  longint      t_plat, t_plon;
  logic [15:0] t_pspd;
  logic [31:0] t_pts, t_lapstart;
  bit          t_have, t_armed;
  logic [1:0]  t_dir;

  // track generator state
  longint      g_clat, g_clon, g_span;
  logic [31:0] g_ts;

  gps_lap_gate_timer_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #8ms;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // idle length: mostly none, a few long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 70);
  endfunction

  function automatic longint sx31(input logic [31:0] v);
    return longint'($signed(v[30:0]));
  endfunction

  function automatic logic signed [127:0] xprod(input longint ax, input longint ay,
                                                input longint bx, input longint by);
    logic signed [127:0] a0, a1, b0, b1;
    a0 = ax; a1 = ay; b0 = bx; b1 = by;
    return a0 * b1 - a1 * b0;
  endfunction

  function automatic int sgn(input logic signed [127:0] v);
    if (v < 0) return -1;
    return (v != 0) ? 1 : 0;
  endfunction

  function automatic bit gate_ok();
    if (c_llat < -900000000 || c_llat > 900000000) return 0;
    if (c_rlat < -900000000 || c_rlat > 900000000) return 0;
    if (c_llon < -64'sd1800000000 || c_llon > 64'sd1800000000) return 0;
    if (c_rlon < -64'sd1800000000 || c_rlon > 64'sd1800000000) return 0;
    return (c_llat != c_rlat) || (c_llon != c_rlon);
  endfunction

  function automatic void apply_cfg(input logic [gpslap_pkg::CfgIdxW-1:0] idx,
                                    input logic [31:0] v);
    case (idx)
      gpslap_pkg::REG_ENABLE: c_en = v[0];
      gpslap_pkg::REG_LLAT:   c_llat = sx31(v);
      gpslap_pkg::REG_LLON:   c_llon = longint'($signed(v));
      gpslap_pkg::REG_RLAT:   c_rlat = sx31(v);
      gpslap_pkg::REG_RLON:   c_rlon = longint'($signed(v));
      gpslap_pkg::REG_MAXGAP: c_maxgap = v[15:0];
      gpslap_pkg::REG_MINSPD: c_minspd = v[15:0];
      gpslap_pkg::REG_MINLAP: c_minlap = v;
      default: ;
    endcase
  endfunction

  // lap predictor: one fix in, at most one lap result queued
  function automatic void predict_lap(input fix_t f);
    longint lat, lon, gx, gy, mx, my;
    logic [31:0] gap, lap, ct;
    logic signed [127:0] ps, cs;
    logic [127:0] a, b, num, den, off;
    int sp, sc, o1, o2;
    logic [1:0] dir;
    lap_t r;
    lat = longint'($signed(f.lat));
    lon = longint'($signed(f.lon));
    if (!c_en || !gate_ok()) return;
    if (t_have) begin
      gap = f.ts - t_pts;
      if (gap != 0 && gap <= c_maxgap &&
          ({1'b0, t_pspd} + {1'b0, f.spd}) >= {c_minspd, 1'b0}) begin
        gx = c_rlon - c_llon;
        gy = c_rlat - c_llat;
        ps = xprod(gx, gy, t_plon - c_llon, t_plat - c_llat);
        cs = xprod(gx, gy, lon - c_llon, lat - c_llat);
        sp = sgn(ps);
        sc = sgn(cs);
        dir = (sp < 0 && sc > 0) ? gpslap_pkg::DIR_NEG_POS :
              (sp > 0 && sc < 0) ? gpslap_pkg::DIR_POS_NEG : gpslap_pkg::DIR_ANY;
        if (dir != gpslap_pkg::DIR_ANY &&
            (t_dir == gpslap_pkg::DIR_ANY || t_dir == dir)) begin
          mx = lon - t_plon;
          my = lat - t_plat;
          o1 = sgn(xprod(mx, my, c_llon - t_plon, c_llat - t_plat));
          o2 = sgn(xprod(mx, my, c_rlon - t_plon, c_rlat - t_plat));
          if (o1 != o2) begin
            a = (ps < 0) ? -ps : ps;
            b = a + ((cs < 0) ? -cs : cs);
            num = a * {gap, 1'b0} + b;
            den = b + b;
            off = (den == 0) ? 128'd0 : num / den;
            if (off > gap) off = gap;
            ct = t_pts + off[31:0];
            if (!t_armed) begin
              t_armed = 1'b1;
              t_lapstart = ct;
              t_dir = dir;
            end else begin
              lap = ct - t_lapstart;
              if (lap >= c_minlap) begin
                t_lapstart = ct;
                r.lap = lap;
                r.ct = ct;
                lap_q.push_back(r);
              end
            end
          end
        end
      end
    end
    t_have = 1'b1;
    t_plat = lat;
    t_plon = lon;
    t_pspd = f.spd;
    t_pts = f.ts;
  endfunction

  // fix driver
  always @(posedge clk) begin
    bit nv;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      nv = s_tvalid;
      if (s_tvalid && s_tready) begin
        predict_lap(cur_fix);
        nv = 1'b0;
      end
      if (!nv) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (fix_q.size() > 0 && !hold_tx) begin
          cur_fix = fix_q.pop_front();
          s_tdata <= {1'b0, cur_fix.ts, cur_fix.spd, cur_fix.lon, cur_fix.lat};
          nv = 1'b1;
          tx_gap = pick_idle();
        end
      end
      s_tvalid <= nv;
    end
  end

  // lap result monitor
  always @(posedge clk) begin
    lap_t e;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (lap_q.size() == 0) begin
          report($sformatf("unexpected lap beat %h", m_tdata));
        end else begin
          e = lap_q.pop_front();
          if (m_tdata[31:0] !== e.lap)
            report($sformatf("lap_time_ms %0d, want %0d", m_tdata[31:0], e.lap));
          if (m_tdata[63:32] !== e.ct)
            report($sformatf("crossing_time_ms %0d, want %0d", m_tdata[63:32], e.ct));
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        rx_stall = pick_idle();
        m_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [gpslap_pkg::CfgIdxW-1:0] idx,
                           input logic [31:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, v);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    wait (fix_q.size() == 0 && !s_tvalid && lap_q.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic push_fix(input longint lat, input longint lon, input int spd,
                          input logic [31:0] ts);
    fix_t f;
    f.lat = lat[30:0];
    f.lon = lon[31:0];
    f.spd = spd[15:0];
    f.ts = ts;
    fix_q.push_back(f);
  endtask

  function automatic longint clip(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint jitter(input longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  // one fix near the gate, mostly with a plausible time step and speed
  task automatic push_track_fix();
    longint lat, lon;
    int r, spd;
    logic [31:0] stepv;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      lat = c_llat;
      lon = c_llon;
    end else begin
      lat = clip(g_clat + jitter(g_span), 900000000);
      lon = clip(g_clon + jitter(g_span), 1800000000);
    end
    r = $urandom_range(0, 99);
    if (r < 4) stepv = 0;
    else if (r < 8) stepv = c_maxgap + $urandom_range(1, 5000);
    else stepv = $urandom_range(1, (c_maxgap == 0) ? 1 : c_maxgap);
    g_ts += stepv;
    spd = ($urandom_range(0, 9) < 8) ? $urandom_range(c_minspd, 65535)
                                     : $urandom_range(0, 65535);
    push_fix(lat, lon, spd, g_ts);
  endtask

  task automatic push_noise_fix();
    fix_t f;
    f.lat = $urandom();
    f.lon = $urandom();
    f.spd = $urandom();
    f.ts = $urandom();
    fix_q.push_back(f);
  endtask

  initial begin
    int ph, k, n, r;
    longint w;
    logic [31:0] v;
    c_en = 0; c_llat = 0; c_llon = 0; c_rlat = 0; c_rlon = 0;
    c_maxgap = 3000; c_minspd = 1000; c_minlap = 10000;
    t_plat = 0; t_plon = 0; t_pspd = 0; t_pts = 0; t_lapstart = 0;
    t_have = 0; t_armed = 0; t_dir = gpslap_pkg::DIR_ANY;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // timing off: fixes ignored
    push_fix(100, 200, 5000, 1000);
    push_fix(-100, 200, 5000, 1100);
    drain();
    // timing on, but both gate ends equal
    write_reg(gpslap_pkg::REG_ENABLE, 1);
    push_fix(100, 200, 5000, 1200);
    drain();
    // horizontal gate from lon -1000 to 1000 at lat 0
    write_reg(gpslap_pkg::REG_LLAT, 0);
    write_reg(gpslap_pkg::REG_LLON, -1000);
    write_reg(gpslap_pkg::REG_RLAT, 0);
    write_reg(gpslap_pkg::REG_RLON, 1000);
    write_reg(gpslap_pkg::REG_MINLAP, 0);
    push_fix(-500, 0, 2000, 1000);      // first fix
    push_fix(500, 0, 2000, 1000);       // zero gap
    push_fix(-500, 10, 2000, 1100);     // crossing, arms
    push_fix(500, 10, 2000, 9000);      // gap too large
    push_fix(-500, 10, 0, 9100);        // zero speed, average still at the minimum
    push_fix(0, 10, 2000, 9200);        // lands on gate line
    push_fix(300, 10, 2000, 9300);      // leaves from the line
    push_fix(-300, 5000, 2000, 9400);   // misses the gate end
    push_fix(300, 20, 2000, 9500);      // wrong direction after lock
    push_fix(-700, -20, 2000, 9600);    // locked direction, lap out
    push_fix(700, 0, 2000, 9601);
    push_fix(-1, 0, 2000, 9603);        // tiny offset, rounding
    push_fix(-1073741824, 32'h80000000, 65535, 32'hFFFFFF00);
    push_fix(1073741823, 32'h7FFFFFFF, 0, 32'hFFFFFFFF);
    push_fix(-5, 0, 65535, 32'h00000005);   // timestamp wraps
    drain();
    // extreme gate and limits
    write_reg(gpslap_pkg::REG_LLAT, -900000000);
    write_reg(gpslap_pkg::REG_LLON, -1800000000);
    write_reg(gpslap_pkg::REG_RLAT, 900000000);
    write_reg(gpslap_pkg::REG_RLON, 1800000000);
    write_reg(gpslap_pkg::REG_MAXGAP, 65535);
    write_reg(gpslap_pkg::REG_MINSPD, 0);
    write_reg(gpslap_pkg::REG_MINLAP, 0);
    push_fix(900000000, -1800000000, 0, 0);
    push_fix(-900000000, 1800000000, 0, 65535);
    push_fix(900000000, -1800000000, 0, 131070);
    push_fix(-900000000, 1800000000, 65535, 131071);
    push_fix(1073741823, -2147483648, 65535, 196606);
    drain();

    // random phases
    for (ph = 0; ph < 12; ph++) begin
      no_idle = (ph == 3);
      write_reg(gpslap_pkg::REG_ENABLE, ($urandom_range(0, 9) != 0) ? 1 : 0);
      r = $urandom_range(0, 2);
      g_span = (r == 0) ? $urandom_range(1, 1000) :
               (r == 1) ? $urandom_range(1000, 10000000) : $urandom_range(100000000, 900000000);
      g_clat = jitter(900000000);
      g_clon = jitter(1800000000);
      if ($urandom_range(0, 9) == 0) begin
        write_reg(gpslap_pkg::REG_LLAT, $urandom());
        write_reg(gpslap_pkg::REG_RLAT, $urandom());
      end else begin
        w = clip(g_clat + jitter(g_span), 900000000);
        write_reg(gpslap_pkg::REG_LLAT, w[31:0]);
        w = clip(g_clat + jitter(g_span), 900000000);
        write_reg(gpslap_pkg::REG_RLAT, w[31:0]);
      end
      w = clip(g_clon + jitter(g_span), 1800000000);
      write_reg(gpslap_pkg::REG_LLON, ($urandom_range(0, 19) == 0) ? $urandom() : w[31:0]);
      w = clip(g_clon + jitter(g_span), 1800000000);
      write_reg(gpslap_pkg::REG_RLON, w[31:0]);
      r = $urandom_range(0, 9);
      v = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(1, 3000);
      write_reg(gpslap_pkg::REG_MAXGAP, v);
      r = $urandom_range(0, 9);
      v = (r == 0) ? 65535 : (r < 4) ? 0 : $urandom_range(1, 2000);
      write_reg(gpslap_pkg::REG_MINSPD, v);
      r = $urandom_range(0, 9);
      v = (r == 0) ? 32'hFFFFFFFF : (r < 4) ? 0 : $urandom_range(1, 3000);
      write_reg(gpslap_pkg::REG_MINLAP, v);
      g_ts = ($urandom_range(0, 3) == 0) ? 32'hFFFF0000 + $urandom_range(0, 65535) : $urandom();
      n = 85;
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 99) < 85) push_track_fix();
        else push_noise_fix();
        // hold the sender once until every lap result is back
        if (ph == 6 && k == 40) begin
          wait (fix_q.size() == 0 && !s_tvalid);
          hold_tx = 1'b1;
          wait (lap_q.size() == 0);
          repeat (70) @(posedge clk);
          hold_tx = 1'b0;
        end
      end
      drain();
    end

    wait (fix_q.size() == 0 && !s_tvalid && lap_q.size() == 0);
    repeat (100) @(posedge clk);
    if (lap_q.size() != 0) report("lap results still outstanding");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
